[src/piece_table_text_insert_defines.svh]
// Assertion macros for the piece table insert block.
// Depends on nothing; taken in by the modules that carry assertions.
`ifndef PIECE_TABLE_TEXT_INSERT_DEFINES_SVH
`define PIECE_TABLE_TEXT_INSERT_DEFINES_SVH

// Clocked assertion, switched off while reset is high
`define PTI_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Same-cycle implication
`define PTI_IMPLY(lbl, ante, cons, msg) \
   `PTI_ASSERT(lbl, (ante) |-> (cons), msg)

// Next-cycle implication
`define PTI_NEXT(lbl, ante, cons, msg) \
   `PTI_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

[src/pti_pkg.sv]
// Shared types, codes and defaults for the piece table insert block.
// Depends on nothing.
package pti_pkg;

   localparam int MAX_PIECES_DEF = 64;
   localparam int ADD_BYTES_DEF  = 4096;
   localparam int POS_W          = 13;

   // result status codes
   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_PENDING    = 3'd1;
   localparam logic [2:0] ST_RANGE      = 3'd2;
   localparam logic [2:0] ST_FULL       = 3'd3;
   localparam logic [2:0] ST_READ_RANGE = 3'd4;

   // datapath commands
   localparam logic [3:0] OP_NONE      = 4'd0;
   localparam logic [3:0] OP_LATCH     = 4'd1;
   localparam logic [3:0] OP_BYTE      = 4'd2;
   localparam logic [3:0] OP_FIRST     = 4'd3;
   localparam logic [3:0] OP_RESULT    = 4'd4;
   localparam logic [3:0] OP_SCAN_INIT = 4'd5;
   localparam logic [3:0] OP_FIND      = 4'd6;
   localparam logic [3:0] OP_PLAN      = 4'd7;
   localparam logic [3:0] OP_SHIFT     = 4'd8;
   localparam logic [3:0] OP_WPRE      = 4'd9;
   localparam logic [3:0] OP_WNEW      = 4'd10;
   localparam logic [3:0] OP_WSUF      = 4'd11;
   localparam logic [3:0] OP_FIN       = 4'd12;
   localparam logic [3:0] OP_RDONE     = 4'd13;
   localparam logic [3:0] OP_SEND      = 4'd14;

   typedef struct packed {
      logic             opcode;
      logic [POS_W-1:0] position;
      logic [7:0]       data_byte;
      logic             run_last;
   } req_type;

   typedef struct packed {
      logic [2:0]       status;
      logic [7:0]       read_byte;
      logic [POS_W-1:0] doc_length;
   } rsp_type;

   typedef struct packed {
      logic [3:0] op;
      logic [2:0] status;
      logic       clear_run;
   } cmd_type;

   typedef struct packed {
      logic opcode;
      logic last;
      logic count_zero;
      logic overflow;
      logic past_end;
      logic read_range;
      logic hit;
      logic over_full;
      logic shift_needed;
      logic shift_more;
      logic has_suffix;
   } flags_type;

endpackage

[src/piece_table_text_insert.sv]
// Top level of the piece table insert block: joins controller and datapath.
// Depends on pti_pkg, pti_ctrl and pti_dpath.
//
// Items are handled one at a time. A byte that is not the last of its run is
// latched, stored and given a pending result, which is then sent; the next
// item is taken once the block is back in idle. A read or a commit walks the
// piece memory through its single registered read port, one piece a cycle,
// until it reaches the piece that holds its position. A commit finds its
// piece the same way, then moves every later piece up by one or two slots,
// one piece a cycle, and writes at most three entries; the walk and the
// moves together cover the table once. A new item is taken while the
// previous result still waits at the output. No clearing pass runs after
// reset: only pieces below the piece count are ever read.
module piece_table_text_insert #(
   parameter int MAX_PIECES = pti_pkg::MAX_PIECES_DEF,
   parameter int ADD_BYTES  = pti_pkg::ADD_BYTES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  pti_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output pti_pkg::rsp_type rsp_payload
);

   pti_pkg::cmd_type   cmd;
   pti_pkg::flags_type flags;

   // sequencer
   pti_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .flags     (flags),
      .cmd       (cmd)
   );

   // storage and arithmetic
   pti_dpath #(
      .MAX_PIECES (MAX_PIECES),
      .ADD_BYTES  (ADD_BYTES)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_payload (req_payload),
      .flags       (flags),
      .rsp_payload (rsp_payload)
   );

endmodule

[src/pti_dpath.sv]
// Datapath of the piece table insert block: piece memory, addition store,
// run and scan registers and the result register. Depends on pti_pkg.
module pti_dpath #(
   parameter int MAX_PIECES = pti_pkg::MAX_PIECES_DEF,
   parameter int ADD_BYTES  = pti_pkg::ADD_BYTES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  pti_pkg::cmd_type   cmd,
   input  pti_pkg::req_type   req_payload,
   output pti_pkg::flags_type flags,
   output pti_pkg::rsp_type   rsp_payload
);

   localparam int LW = $clog2(ADD_BYTES + 1);
   localparam int SW = $clog2(ADD_BYTES);
   localparam int PW = $clog2(MAX_PIECES);
   localparam int NW = $clog2(MAX_PIECES + 1);
   localparam int CW = (LW > pti_pkg::POS_W) ? LW : pti_pkg::POS_W;

   // memories
   logic [SW-1:0] piece_start_ff [MAX_PIECES];
   logic [LW-1:0] piece_len_ff   [MAX_PIECES];
   logic [7:0]    store_ff       [ADD_BYTES];
   logic [SW-1:0] start_q_ff;
   logic [LW-1:0] len_q_ff;
   logic [7:0]    store_q_ff;

   // registers
   pti_pkg::req_type   itm_ff, itm_in;
   pti_pkg::rsp_type   rsp_ff, rsp_in;
   logic [LW-1:0]      tail_ff, tail_in, rlen_ff, rlen_in;
   logic [pti_pkg::POS_W-1:0] rpos_ff, rpos_in;
   logic               rovf_ff, rovf_in;
   logic [NW-1:0]      count_ff, count_in;
   logic [PW-1:0]      idx_ff, idx_in, hit_ff, hit_in, sidx_ff, sidx_in, widx_ff, widx_in;
   logic [LW-1:0]      offset_ff, offset_in, local_ff, local_in, olen_ff, olen_in;
   logic [SW-1:0]      ostart_ff, ostart_in;
   logic [2:0]         res_status_ff, res_status_in;
   logic [7:0]         res_byte_ff, res_byte_in;

   // memory ports
   logic          pw_en, sw_en;
   logic [PW-1:0] pw_addr, pr_addr;
   logic [SW-1:0] pw_start, sw_addr, sr_addr;
   logic [LW-1:0] pw_len;

   // arithmetic
   logic [CW-1:0] sel_pos;
   logic [CW:0]   end_sum;
   logic [CW-1:0] pos_diff;
   logic [LW-1:0] local_calc;
   logic [LW:0]   fill;
   logic          room;
   logic [1:0]    added;
   logic [PW+1:0] hit_next, count_x, sidx_x;
   logic [PW:0]   shift_dst;

   // compare the scan position with the end of the current piece; store fill, room and the split and shift arithmetic
   always_comb begin
      sel_pos    = itm_ff.opcode ? CW'(itm_ff.position) : CW'(rpos_ff);
      end_sum    = (CW+1)'(offset_ff) + (CW+1)'(len_q_ff);
      pos_diff   = sel_pos - CW'(offset_ff);
      local_calc = pos_diff[LW-1:0];
      fill       = (LW+1)'(tail_ff) + (LW+1)'(rlen_ff);
      room       = !rovf_ff && (fill < (LW+1)'(ADD_BYTES));
      added      = 2'((local_ff != '0) ? 1 : 0) + 2'((local_ff < olen_ff) ? 1 : 0);
      hit_next   = (PW+2)'(hit_ff) + (PW+2)'(1);
      count_x    = (PW+2)'(count_ff);
      sidx_x     = (PW+2)'(sidx_ff);
      shift_dst  = (PW+1)'(sidx_ff) + (PW+1)'(added);
      sr_addr    = SW'((LW+1)'(start_q_ff) + (LW+1)'(local_calc));
   end

   // status towards the controller
   always_comb begin
      flags.opcode       = itm_ff.opcode;
      flags.last         = itm_ff.run_last;
      flags.count_zero   = (count_ff == '0);
      flags.overflow     = rovf_ff;
      flags.past_end     = CW'(rpos_ff) > CW'(tail_ff);
      flags.read_range   = CW'(itm_ff.position) >= CW'(tail_ff);
      flags.hit          = itm_ff.opcode ? ((CW+1)'(sel_pos) < end_sum)
                                         : ((CW+1)'(sel_pos) <= end_sum);
      flags.over_full    = ((NW+2)'(count_ff) + (NW+2)'(added)) > (NW+2)'(MAX_PIECES);
      flags.shift_needed = count_x > hit_next;
      flags.shift_more   = sidx_x > hit_next;
      flags.has_suffix   = local_ff < olen_ff;
   end

   // decode the command
   always_comb begin
      itm_in        = itm_ff;
      rsp_in        = rsp_ff;
      tail_in       = tail_ff;
      rlen_in       = rlen_ff;
      rpos_in       = rpos_ff;
      rovf_in       = rovf_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      hit_in        = hit_ff;
      sidx_in       = sidx_ff;
      widx_in       = widx_ff;
      offset_in     = offset_ff;
      local_in      = local_ff;
      olen_in       = olen_ff;
      ostart_in     = ostart_ff;
      res_status_in = res_status_ff;
      res_byte_in   = res_byte_ff;
      pw_en         = 1'b0;
      pw_addr       = '0;
      pw_start      = start_q_ff;
      pw_len        = len_q_ff;
      pr_addr       = idx_ff;
      sw_en         = 1'b0;
      sw_addr       = fill[SW-1:0];
      case (cmd.op)
         pti_pkg::OP_LATCH: begin
            itm_in = req_payload;
         end
         pti_pkg::OP_BYTE: begin
            if (rlen_ff == '0 && !rovf_ff) begin
               rpos_in = itm_ff.position;
            end
            if (room) begin
               sw_en   = 1'b1;
               rlen_in = rlen_ff + LW'(1);
            end else begin
               rovf_in = 1'b1;
            end
         end
         pti_pkg::OP_FIRST: begin
            pw_en         = 1'b1;
            pw_start      = tail_ff[SW-1:0];
            pw_len        = rlen_ff;
            count_in      = NW'(1);
            tail_in       = tail_ff + rlen_ff;
            res_status_in = pti_pkg::ST_OK;
            res_byte_in   = '0;
            rlen_in       = '0;
            rpos_in       = '0;
            rovf_in       = 1'b0;
         end
         pti_pkg::OP_RESULT: begin
            res_status_in = cmd.status;
            res_byte_in   = '0;
            if (cmd.clear_run) begin
               rlen_in = '0;
               rpos_in = '0;
               rovf_in = 1'b0;
            end
         end
         pti_pkg::OP_SCAN_INIT: begin
            idx_in    = '0;
            offset_in = '0;
            pr_addr   = '0;
         end
         pti_pkg::OP_FIND: begin
            if (flags.hit) begin
               hit_in    = idx_ff;
               ostart_in = start_q_ff;
               olen_in   = len_q_ff;
               local_in  = local_calc;
            end else begin
               offset_in = end_sum[LW-1:0];
               idx_in    = idx_ff + PW'(1);
               pr_addr   = idx_ff + PW'(1);
            end
         end
         pti_pkg::OP_PLAN: begin
            sidx_in = PW'(count_ff - NW'(1));
            pr_addr = PW'(count_ff - NW'(1));
         end
         pti_pkg::OP_SHIFT: begin
            pw_en   = 1'b1;
            pw_addr = shift_dst[PW-1:0];
            if (flags.shift_more) begin
               sidx_in = sidx_ff - PW'(1);
               pr_addr = sidx_ff - PW'(1);
            end
         end
         pti_pkg::OP_WPRE: begin
            if (local_ff != '0) begin
               pw_en    = 1'b1;
               pw_addr  = hit_ff;
               pw_start = ostart_ff;
               pw_len   = local_ff;
               widx_in  = hit_ff + PW'(1);
            end else begin
               widx_in  = hit_ff;
            end
         end
         pti_pkg::OP_WNEW: begin
            pw_en    = 1'b1;
            pw_addr  = widx_ff;
            pw_start = tail_ff[SW-1:0];
            pw_len   = rlen_ff;
            widx_in  = widx_ff + PW'(1);
         end
         pti_pkg::OP_WSUF: begin
            pw_en    = 1'b1;
            pw_addr  = widx_ff;
            pw_start = SW'((LW+1)'(ostart_ff) + (LW+1)'(local_ff));
            pw_len   = olen_ff - local_ff;
         end
         pti_pkg::OP_FIN: begin
            count_in      = count_ff + NW'(added);
            tail_in       = tail_ff + rlen_ff;
            res_status_in = pti_pkg::ST_OK;
            res_byte_in   = '0;
            rlen_in       = '0;
            rpos_in       = '0;
            rovf_in       = 1'b0;
         end
         pti_pkg::OP_RDONE: begin
            res_status_in = pti_pkg::ST_OK;
            res_byte_in   = store_q_ff;
         end
         pti_pkg::OP_SEND: begin
            rsp_in.status     = res_status_ff;
            rsp_in.read_byte  = res_byte_ff;
            rsp_in.doc_length = pti_pkg::POS_W'(CW'(tail_ff));
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tail_ff  <= '0;
         rlen_ff  <= '0;
         rpos_ff  <= '0;
         rovf_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         tail_ff  <= tail_in;
         rlen_ff  <= rlen_in;
         rpos_ff  <= rpos_in;
         rovf_ff  <= rovf_in;
         count_ff <= count_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      itm_ff        <= itm_in;
      rsp_ff        <= rsp_in;
      idx_ff        <= idx_in;
      hit_ff        <= hit_in;
      sidx_ff       <= sidx_in;
      widx_ff       <= widx_in;
      offset_ff     <= offset_in;
      local_ff      <= local_in;
      olen_ff       <= olen_in;
      ostart_ff     <= ostart_in;
      res_status_ff <= res_status_in;
      res_byte_ff   <= res_byte_in;
   end

   // piece memory, one write and one registered read
   always_ff @(posedge clock) begin
      if (pw_en) begin
         piece_start_ff[pw_addr] <= pw_start;
         piece_len_ff[pw_addr]   <= pw_len;
      end
      start_q_ff <= piece_start_ff[pr_addr];
      len_q_ff   <= piece_len_ff[pr_addr];
   end

   // addition store
   always_ff @(posedge clock) begin
      if (sw_en) begin
         store_ff[sw_addr] <= itm_ff.data_byte;
      end
      store_q_ff <= store_ff[sr_addr];
   end

   assign rsp_payload = rsp_ff;

endmodule

[src/pti_ctrl.sv]
// Controller of the piece table insert block: sequences byte, commit and
// read items. Depends on pti_pkg and the assertion macro header.
`include "piece_table_text_insert_defines.svh"

module pti_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   input  pti_pkg::flags_type flags,
   output pti_pkg::cmd_type   cmd
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DECODE = 4'd1;
   localparam logic [3:0] S_COMMIT = 4'd2;
   localparam logic [3:0] S_FIND   = 4'd3;
   localparam logic [3:0] S_PLAN   = 4'd4;
   localparam logic [3:0] S_SHIFT  = 4'd5;
   localparam logic [3:0] S_WPRE   = 4'd6;
   localparam logic [3:0] S_WNEW   = 4'd7;
   localparam logic [3:0] S_WSUF   = 4'd8;
   localparam logic [3:0] S_FIN    = 4'd9;
   localparam logic [3:0] S_RDATA  = 4'd10;
   localparam logic [3:0] S_DONE   = 4'd11;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // choose the command and the next state
   always_comb begin
      state_in      = state_ff;
      cmd.op        = pti_pkg::OP_NONE;
      cmd.status    = pti_pkg::ST_OK;
      cmd.clear_run = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = pti_pkg::OP_LATCH;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (!flags.opcode) begin
               cmd.op   = pti_pkg::OP_BYTE;
               state_in = S_COMMIT;
            end else if (flags.read_range) begin
               cmd.op     = pti_pkg::OP_RESULT;
               cmd.status = pti_pkg::ST_READ_RANGE;
               state_in   = S_DONE;
            end else begin
               cmd.op   = pti_pkg::OP_SCAN_INIT;
               state_in = S_FIND;
            end
         end
         S_COMMIT: begin
            state_in = S_DONE;
            if (!flags.last) begin
               cmd.op     = pti_pkg::OP_RESULT;
               cmd.status = pti_pkg::ST_PENDING;
            end else if (flags.count_zero && !flags.overflow) begin
               cmd.op = pti_pkg::OP_FIRST;
            end else if (flags.count_zero || (!flags.past_end && flags.overflow)) begin
               cmd.op        = pti_pkg::OP_RESULT;
               cmd.status    = pti_pkg::ST_FULL;
               cmd.clear_run = 1'b1;
            end else if (flags.past_end) begin
               cmd.op        = pti_pkg::OP_RESULT;
               cmd.status    = pti_pkg::ST_RANGE;
               cmd.clear_run = 1'b1;
            end else begin
               cmd.op   = pti_pkg::OP_SCAN_INIT;
               state_in = S_FIND;
            end
         end
         S_FIND: begin
            cmd.op = pti_pkg::OP_FIND;
            if (flags.hit) begin
               state_in = flags.opcode ? S_RDATA : S_PLAN;
            end
         end
         S_PLAN: begin
            if (flags.over_full) begin
               cmd.op        = pti_pkg::OP_RESULT;
               cmd.status    = pti_pkg::ST_FULL;
               cmd.clear_run = 1'b1;
               state_in      = S_DONE;
            end else begin
               cmd.op   = pti_pkg::OP_PLAN;
               state_in = flags.shift_needed ? S_SHIFT : S_WPRE;
            end
         end
         S_SHIFT: begin
            cmd.op   = pti_pkg::OP_SHIFT;
            state_in = flags.shift_more ? S_SHIFT : S_WPRE;
         end
         S_WPRE: begin
            cmd.op   = pti_pkg::OP_WPRE;
            state_in = S_WNEW;
         end
         S_WNEW: begin
            cmd.op   = pti_pkg::OP_WNEW;
            state_in = flags.has_suffix ? S_WSUF : S_FIN;
         end
         S_WSUF: begin
            cmd.op   = pti_pkg::OP_WSUF;
            state_in = S_FIN;
         end
         S_FIN: begin
            cmd.op   = pti_pkg::OP_FIN;
            state_in = S_DONE;
         end
         S_RDATA: begin
            cmd.op   = pti_pkg::OP_RDONE;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.op   = pti_pkg::OP_SEND;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // hold the result until taken, load it on send
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.op == pti_pkg::OP_SEND) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   `PTI_IMPLY(a_send_free, cmd.op == pti_pkg::OP_SEND, !rsp_valid_ff || !rsp_stall, "send over an untaken item")
   `PTI_NEXT(a_accept_busy, req_valid && !req_stall, state_ff == S_DECODE, "accepted item not decoded")
   `PTI_IMPLY(a_shift_nonempty, state_ff == S_SHIFT, !flags.count_zero, "shift on an empty table")
   `PTI_NEXT(a_send_valid, cmd.op == pti_pkg::OP_SEND, rsp_valid_ff, "sent item not shown")

endmodule

[bench/tb_piece_table_text_insert.sv]
// Self-checking bench for the piece table insert block: predicts each result
// from its own piece list and byte store. Depends on pti_pkg and the RTL.
module tb_piece_table_text_insert;

   localparam int NPIECE = pti_pkg::MAX_PIECES_DEF;
   localparam int NBYTE  = pti_pkg::ADD_BYTES_DEF;
   localparam int LIMIT  = 2000000;

   // predictor state and expected results
   class text_scoreboard;
      int unsigned      seg_start [NPIECE];
      int unsigned      seg_len [NPIECE];
      int unsigned      seg_count, tail, pend_len, pend_pos;
      bit               pend_over;
      logic [7:0]       store [NBYTE];
      pti_pkg::rsp_type awaited [$];
      int               errors;

      function int unsigned total();
         int unsigned s;
         s = 0;
         for (int i = 0; i < seg_count; i++) s += seg_len[i];
         return s;
      endfunction

      function logic [2:0] commit();
         int unsigned off, hit, loc, add, os, ol, j;
         off = 0; hit = 0;
         if (seg_count == 0) begin
            if (pend_over) return pti_pkg::ST_FULL;
            seg_start[0] = tail; seg_len[0] = pend_len; seg_count = 1;
            tail += pend_len;
            return pti_pkg::ST_OK;
         end
         if (pend_pos > total()) return pti_pkg::ST_RANGE;
         if (pend_over) return pti_pkg::ST_FULL;
         for (int i = 0; i < seg_count; i++) begin
            if (pend_pos <= off + seg_len[i]) begin
               hit = i;
               break;
            end
            off += seg_len[i];
         end
         os = seg_start[hit]; ol = seg_len[hit]; loc = pend_pos - off;
         add = (loc > 0) + (loc < ol);
         if (seg_count + add > NPIECE) return pti_pkg::ST_FULL;
         for (j = seg_count; j > hit + 1; j--) begin
            seg_start[j-1+add] = seg_start[j-1];
            seg_len[j-1+add] = seg_len[j-1];
         end
         j = hit;
         if (loc > 0) begin
            seg_start[j] = os; seg_len[j] = loc; j++;
         end
         seg_start[j] = tail; seg_len[j] = pend_len; j++;
         if (loc < ol) begin
            seg_start[j] = os + loc; seg_len[j] = ol - loc;
         end
         seg_count += add;
         tail += pend_len;
         return pti_pkg::ST_OK;
      endfunction

      // note an accepted item and queue its result
      function void note_item(pti_pkg::req_type r);
         pti_pkg::rsp_type e;
         int unsigned off;
         e = '0;
         if (r.opcode) begin
            if (r.position >= total()) e.status = pti_pkg::ST_READ_RANGE;
            else begin
               e.status = pti_pkg::ST_OK; off = 0;
               for (int i = 0; i < seg_count; i++) begin
                  if (r.position < off + seg_len[i]) begin
                     e.read_byte = store[seg_start[i] + r.position - off];
                     break;
                  end
                  off += seg_len[i];
               end
            end
         end else begin
            if (pend_len == 0 && !pend_over) pend_pos = r.position;
            if (!pend_over && tail + pend_len < NBYTE) begin
               store[tail + pend_len] = r.data_byte;
               pend_len++;
            end else pend_over = 1;
            if (r.run_last) begin
               e.status = commit();
               pend_len = 0; pend_pos = 0; pend_over = 0;
            end else e.status = pti_pkg::ST_PENDING;
         end
         e.doc_length = 13'(total());
         awaited = {awaited, e};
      endfunction

      task report(string what);
         $display("mismatch: %s", what);
         errors++;
      endtask

      // compare one accepted result with the oldest expectation
      task check_result(pti_pkg::rsp_type g);
         pti_pkg::rsp_type e;
         if (awaited.size() == 0) begin
            report("result with nothing expected");
            return;
         end
         e = awaited.pop_front();
         if (g.status !== e.status)
            report($sformatf("status got %0d want %0d", g.status, e.status));
         if (g.read_byte !== e.read_byte)
            report($sformatf("read_byte got %0h want %0h", g.read_byte, e.read_byte));
         if (g.doc_length !== e.doc_length)
            report($sformatf("doc_length got %0d want %0d", g.doc_length, e.doc_length));
      endtask
   endclass

   logic             clock = 0, reset = 1;
   logic             req_valid = 0, rsp_stall = 0, req_stall, rsp_valid;
   pti_pkg::req_type req_payload = '0;
   pti_pkg::rsp_type rsp_payload;
   int               send_idle = 0, recv_stall = 0, hold_off = 0;
   longint           cycles = 0;
   text_scoreboard   board = new();

   piece_table_text_insert dut (.*);

   always #5 clock = ~clock;

   // sample both channels at the rising edge
   always @(posedge clock) begin
      cycles++;
      if (!reset) begin
         if (req_valid && !req_stall) board.note_item(req_payload);
         if (rsp_valid && !rsp_stall) board.check_result(rsp_payload);
      end
      if (cycles > LIMIT) begin
         $display("[piece_table_text_insert] ERROR");
         $finish;
      end
   end

   // receiver: random stall, or a long hold-off counted here
   always @(negedge clock) begin
      if (hold_off > 0) begin
         rsp_stall <= 1;
         hold_off <= hold_off - 1;
      end else rsp_stall <= ($urandom_range(99) < recv_stall);
   end

   // offer one item and hold it until it is taken
   task automatic send(bit op, int pos, int b, bit last);
      pti_pkg::req_type r;
      r.opcode = op; r.position = 13'(pos); r.data_byte = 8'(b); r.run_last = last;
      while ($urandom_range(99) < send_idle) begin
         @(negedge clock);
         req_valid <= 0;
      end
      @(negedge clock);
      req_valid <= 1; req_payload <= r;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      req_valid <= 0;
   endtask

   task automatic insert_run(int pos, int len);
      for (int i = 0; i < len; i++) send(0, pos ^ (i ? $urandom : 0), $urandom, i == len - 1);
   endtask

   task automatic random_phase(int n);
      int d, k;
      k = 0;
      while (k < n) begin
         d = board.total();
         case ($urandom_range(9))
            0: begin send(1, $urandom_range(8191), 0, $urandom); k++; end
            1, 2, 3: begin send(1, d ? $urandom_range(d - 1) : 0, $urandom, $urandom); k++; end
            4: begin send(0, $urandom_range(d + 3), $urandom, $urandom); k++; end
            default: begin
               d = $urandom_range(1, 5);
               insert_run($urandom_range(4) ? $urandom_range(board.total()) :
                          $urandom_range(8191), d);
               k += d;
            end
         endcase
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      // directed: empty table, ends, middle, past end, reads
      send(1, 0, 0, 0);
      insert_run(4000, 3);
      insert_run(0, 2);
      insert_run(board.total(), 2);
      insert_run(2, 3);
      insert_run(board.total() + 1, 2);
      send(0, 8191, 8'hff, 0);
      send(1, 0, 8'hff, 1);
      send(0, 1, 8'h00, 1);
      send(1, 0, 0, 0);
      send(1, board.total() - 1, 0, 0);
      send(1, board.total(), 0, 0);
      send(1, 8191, 0, 1);
      // idling phases
      random_phase(150);
      send_idle = 68; random_phase(150);
      send_idle = 0; recv_stall = 68; random_phase(150);
      send_idle = 26; recv_stall = 26; random_phase(150);
      recv_stall = 0; send_idle = 0;
      // long receiver hold-off while items keep coming
      @(negedge clock);
      hold_off = 400;
      random_phase(40);
      // fill the table, then push long runs against a full table
      random_phase(200);
      repeat (4) insert_run($urandom_range(board.total()), 40);
      insert_run(board.total(), 30);
      insert_run(0, 3);
      send(1, 0, 0, 0);
      while (board.awaited.size() != 0 && cycles < LIMIT) @(posedge clock);
      repeat (200) @(posedge clock);
      if (board.errors == 0 && board.awaited.size() == 0)
         $display("[piece_table_text_insert] OK");
      else
         $display("[piece_table_text_insert] ERROR");
      $finish;
   end
endmodule
